// ===== src/cie_pkg.sv =====
// types, constants and mnemonic lookup functions for the compute-instruction encoder
// no dependencies; imported by c_instruction_encoder
`timescale 1ns / 1ps

package cie_pkg;

  // longest mnemonic held in the token buffer
  localparam int unsigned TOKEN_CHARS = 3;
  localparam int unsigned LEN_W = 2;
  localparam int unsigned KEY_W = LEN_W + 8 * TOKEN_CHARS;

  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_OVERFLOW = 2'd1;
  localparam logic [1:0] ERR_UNKNOWN  = 2'd2;

  localparam logic [2:0] PREFIX_C = 3'b111;

  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef logic [KEY_W-1:0] key_t;

  typedef struct packed {
    logic       hit;
    logic [6:0] code;
  } lookup_t;

  // token length and its characters, unused character slots forced to zero
  function automatic key_t make_key(input logic [LEN_W-1:0] len, input logic [7:0] c0,
                                    input logic [7:0] c1, input logic [7:0] c2);
    logic [7:0] m0, m1, m2;
    m0 = (len >= 2'd1) ? c0 : 8'h00;
    m1 = (len >= 2'd2) ? c1 : 8'h00;
    m2 = (len >= 2'd3) ? c2 : 8'h00;
    return {len, m0, m1, m2};
  endfunction

  function automatic lookup_t dest_lookup(input key_t key);
    lookup_t r;
    r.hit  = 1'b1;
    r.code = 7'd0;
    case (key)
      {2'd0, 24'h0}:              r.code = 7'd0;
      {2'd1, "M", 16'h0}:         r.code = 7'd1;
      {2'd1, "D", 16'h0}:         r.code = 7'd2;
      {2'd2, "MD", 8'h0}:         r.code = 7'd3;
      {2'd1, "A", 16'h0}:         r.code = 7'd4;
      {2'd2, "AM", 8'h0}:         r.code = 7'd5;
      {2'd2, "AD", 8'h0}:         r.code = 7'd6;
      {2'd3, "AMD"}:              r.code = 7'd7;
      default:                    r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  function automatic lookup_t jump_lookup(input key_t key);
    lookup_t r;
    r.hit  = 1'b1;
    r.code = 7'd0;
    case (key)
      {2'd0, 24'h0}:              r.code = 7'd0;
      {2'd3, "JGT"}:              r.code = 7'd1;
      {2'd3, "JEQ"}:              r.code = 7'd2;
      {2'd3, "JGE"}:              r.code = 7'd3;
      {2'd3, "JLT"}:              r.code = 7'd4;
      {2'd3, "JNE"}:              r.code = 7'd5;
      {2'd3, "JLE"}:              r.code = 7'd6;
      {2'd3, "JMP"}:              r.code = 7'd7;
      default:                    r.hit  = 1'b0;
    endcase
    return r;
  endfunction

  function automatic lookup_t comp_lookup(input key_t key);
    lookup_t r;
    r.hit  = 1'b1;
    r.code = 7'd0;
    case (key)
      {2'd1, "0", 16'h0}:         r.code = 7'h2A;
      {2'd1, "1", 16'h0}:         r.code = 7'h3F;
      {2'd2, "-1", 8'h0}:         r.code = 7'h3A;
      {2'd1, "D", 16'h0}:         r.code = 7'h0C;
      {2'd1, "A", 16'h0}:         r.code = 7'h30;
      {2'd1, "M", 16'h0}:         r.code = 7'h70;
      {2'd2, "!D", 8'h0}:         r.code = 7'h0D;
      {2'd2, "!A", 8'h0}:         r.code = 7'h31;
      {2'd2, "!M", 8'h0}:         r.code = 7'h71;
      {2'd2, "-D", 8'h0}:         r.code = 7'h0F;
      {2'd2, "-A", 8'h0}:         r.code = 7'h33;
      {2'd2, "-M", 8'h0}:         r.code = 7'h73;
      {2'd3, "D+1"}, {2'd3, "1+D"}: r.code = 7'h1F;
      {2'd3, "A+1"}, {2'd3, "1+A"}: r.code = 7'h37;
      {2'd3, "M+1"}, {2'd3, "1+M"}: r.code = 7'h77;
      {2'd3, "D-1"}:              r.code = 7'h0E;
      {2'd3, "A-1"}:              r.code = 7'h32;
      {2'd3, "M-1"}:              r.code = 7'h72;
      {2'd3, "D+A"}, {2'd3, "A+D"}: r.code = 7'h02;
      {2'd3, "D+M"}, {2'd3, "M+D"}: r.code = 7'h42;
      {2'd3, "D-A"}:              r.code = 7'h13;
      {2'd3, "D-M"}:              r.code = 7'h53;
      {2'd3, "A-D"}:              r.code = 7'h07;
      {2'd3, "M-D"}:              r.code = 7'h47;
      {2'd3, "D&A"}:              r.code = 7'h00;
      {2'd3, "D&M"}:              r.code = 7'h40;
      {2'd3, "D|A"}:              r.code = 7'h15;
      {2'd3, "D|M"}:              r.code = 7'h55;
      default:                    r.hit  = 1'b0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/c_instruction_encoder.sv =====
// compute-instruction encoder: one character per beat in, one 16-bit word per line out
// Depends on cie_pkg for the mnemonic tables and error codes.
//
// Usage:
//   s_axis carries one ASCII character per beat in tdata, tlast marks the final
//   character of an instruction line. Whitespace is skipped, '=' closes the
//   destination token, ';' the compute token, '/' starts a comment running to
//   the end of the line. m_axis carries one beat per line: the word
//   111 comp7 dest3 jump3 with an error code (zero word on error).
//   Throughput: one character per cycle while s_axis_tready_o is high; the table
//   matches and the token state update sit in one combinational pass from the line state registers.
//   The result beat is registered: it enters the result register, or the skid
//   register while the result register still holds a beat not yet taken.
//   A two-entry output buffer (result register plus skid register) lets the
//   input keep taking characters while a result waits; s_axis_tready_o drops
//   only when both entries hold results the receiver has not yet taken.
//   Reset clears the line state and empties the output buffer.
`timescale 1ns / 1ps

module c_instruction_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] ch
  input  logic        s_axis_tlast_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o    // [15:0] word, [17:16] error, [23:18] zero
);

  import cie_pkg::*;

  logic [7:0]       tok_q [TOKEN_CHARS];
  logic [7:0]       tok_d [TOKEN_CHARS];
  logic [LEN_W-1:0] len_q, len_d;
  logic             ovf_q, ovf_d;
  logic [2:0]       dest_q, dest_d;
  logic [6:0]       comp_q, comp_d;
  logic             seen_q, seen_d;
  logic             fail_q, fail_d;
  logic             cmt_q, cmt_d;

  logic [17:0]      res;
  logic [17:0]      out_q, skid_q;
  logic             out_valid_q, skid_valid_q;

  logic             accept, push, pop, is_space, is_tok;
  key_t             key_cur, key_fin;
  lookup_t          dest_hit, comp_hit, fin_comp, fin_jump;
  logic [6:0]       comp_fin;
  logic [2:0]       jump_fin;
  logic             fail_fin;

  assign s_axis_tready_o = ~skid_valid_q;
  assign accept = s_axis_tvalid_i & s_axis_tready_o;
  assign push   = accept & s_axis_tlast_i;
  assign pop    = out_valid_q & m_axis_tready_i;

  assign is_space = (s_axis_tdata_i == 8'h20) || (s_axis_tdata_i == 8'h09) ||
                    (s_axis_tdata_i == 8'h0D) || (s_axis_tdata_i == 8'h0A) ||
                    (s_axis_tdata_i == 8'h0B) || (s_axis_tdata_i == 8'h0C);
  assign is_tok   = ~cmt_q & ~is_space;

  assign key_cur  = make_key(len_q, tok_q[0], tok_q[1], tok_q[2]);
  assign dest_hit = dest_lookup(key_cur);
  assign comp_hit = comp_lookup(key_cur);

  // token state after this character
  always_comb begin
    tok_d  = tok_q;
    len_d  = len_q;
    ovf_d  = ovf_q;
    dest_d = dest_q;
    comp_d = comp_q;
    seen_d = seen_q;
    fail_d = fail_q;
    cmt_d  = cmt_q;
    if (is_tok) begin
      case (s_axis_tdata_i)
        CH_EQ: begin
          if (!ovf_q) begin
            if (dest_hit.hit) dest_d = dest_hit.code[2:0];
            else fail_d = 1'b1;
          end
          len_d = '0;
        end
        CH_SEMI: begin
          if (!ovf_q) begin
            if (comp_hit.hit) comp_d = comp_hit.code;
            else fail_d = 1'b1;
          end
          len_d  = '0;
          seen_d = 1'b1;
        end
        CH_SLASH: cmt_d = 1'b1;
        default: begin
          if (len_q < LEN_W'(TOKEN_CHARS)) begin
            tok_d[len_q] = s_axis_tdata_i;
            len_d = len_q + 1'b1;
          end else begin
            ovf_d = 1'b1;
          end
        end
      endcase
    end
  end

  // closing the pending token at the end of the line
  assign key_fin  = make_key(len_d, tok_d[0], tok_d[1], tok_d[2]);
  assign fin_comp = comp_lookup(key_fin);
  assign fin_jump = jump_lookup(key_fin);

  always_comb begin
    comp_fin = comp_d;
    jump_fin = 3'd0;
    fail_fin = fail_d;
    if (!ovf_d) begin
      if (seen_d) begin
        if (fin_jump.hit) jump_fin = fin_jump.code[2:0];
        else fail_fin = 1'b1;
      end else begin
        if (fin_comp.hit) comp_fin = fin_comp.code;
        else fail_fin = 1'b1;
      end
    end
    if (ovf_d) begin
      res = {ERR_OVERFLOW, 16'h0000};
    end else if (fail_fin) begin
      res = {ERR_UNKNOWN, 16'h0000};
    end else begin
      res = {ERR_NONE, PREFIX_C, comp_fin, dest_d, jump_fin};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ovf_q  <= 1'b0;
      dest_q <= '0;
      comp_q <= '0;
      seen_q <= 1'b0;
      fail_q <= 1'b0;
      cmt_q  <= 1'b0;
      for (int i = 0; i < TOKEN_CHARS; i++) tok_q[i] <= '0;
    end else if (accept) begin
      if (s_axis_tlast_i) begin
        len_d_clear: begin
          len_q  <= '0;
          ovf_q  <= 1'b0;
          dest_q <= '0;
          comp_q <= '0;
          seen_q <= 1'b0;
          fail_q <= 1'b0;
          cmt_q  <= 1'b0;
          for (int i = 0; i < TOKEN_CHARS; i++) tok_q[i] <= '0;
        end
      end else begin
        len_q  <= len_d;
        ovf_q  <= ovf_d;
        dest_q <= dest_d;
        comp_q <= comp_d;
        seen_q <= seen_d;
        fail_q <= fail_d;
        cmt_q  <= cmt_d;
        tok_q  <= tok_d;
      end
    end
  end

  // result register with a skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || pop) begin
      if (skid_valid_q) begin
        out_valid_q  <= 1'b1;
        skid_valid_q <= 1'b0;
      end else begin
        out_valid_q  <= push;
      end
    end else if (push) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || pop) begin
      if (skid_valid_q) out_q <= skid_q;
      else if (push) out_q <= res;
    end else if (push) begin
      skid_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_q};

endmodule

// ===== test/c_instruction_encoder_tb.sv =====
// self-checking testbench for c_instruction_encoder: random instruction lines in, encoded words out
// depends on cie_pkg and c_instruction_encoder; a line-level encoder model predicts each word
`timescale 1ns / 1ps

module c_instruction_encoder_tb;
  import cie_pkg::*;

  localparam int unsigned CHAR_TARGET = 1950;
  localparam int unsigned IDLE_LIMIT  = 5000;

  typedef bit [25:0] token_key_t;   // {length, first, second, third char}

  typedef struct {
    logic [15:0] word;
    logic [1:0]  err;
  } line_result_t;

  // line-level model of the encoder plus the queue of words it still expects
  class line_encoder_model;
    string      dest_mn[8];
    string      jump_mn[8];
    string      comp_mn[33];
    bit [6:0]   comp_cd[33];
    bit [6:0]   dest_map[token_key_t];
    bit [6:0]   jump_map[token_key_t];
    bit [6:0]   comp_map[token_key_t];

    bit [7:0]   tok[TOKEN_CHARS];
    int unsigned tok_len;
    bit         overflow;
    bit         comp_seen;
    bit         failed;
    bit         in_comment;
    bit [2:0]   dest;
    bit [6:0]   comp;

    line_result_t pending_words[$];
    int unsigned  mismatches;
    int unsigned  words_seen;

    function new();
      dest_mn = '{"", "M", "D", "MD", "A", "AM", "AD", "AMD"};
      jump_mn = '{"", "JGT", "JEQ", "JGE", "JLT", "JNE", "JLE", "JMP"};
      comp_mn = '{"0", "1", "-1", "D", "A", "M", "!D", "!A", "!M", "-D", "-A", "-M",
                  "D+1", "1+D", "A+1", "M+1", "1+A", "1+M", "D-1", "A-1", "M-1",
                  "D+A", "D+M", "A+D", "M+D", "D-A", "D-M", "A-D", "M-D",
                  "D&A", "D&M", "D|A", "D|M"};
      comp_cd = '{7'h2A, 7'h3F, 7'h3A, 7'h0C, 7'h30, 7'h70, 7'h0D, 7'h31, 7'h71, 7'h0F,
                  7'h33, 7'h73, 7'h1F, 7'h1F, 7'h37, 7'h77, 7'h37, 7'h77, 7'h0E, 7'h32,
                  7'h72, 7'h02, 7'h42, 7'h02, 7'h42, 7'h13, 7'h53, 7'h07, 7'h47, 7'h00,
                  7'h40, 7'h15, 7'h55};
      for (int i = 0; i < 8; i++) begin
        dest_map[text_key(dest_mn[i])] = 7'(i);
        jump_map[text_key(jump_mn[i])] = 7'(i);
      end
      for (int i = 0; i < 33; i++) comp_map[text_key(comp_mn[i])] = comp_cd[i];
      clear_line();
      mismatches = 0;
      words_seen = 0;
    endfunction

    function token_key_t text_key(string s);
      token_key_t k;
      k = '0;
      k[25:24] = 2'(s.len());
      for (int i = 0; i < s.len(); i++) k[23-8*i -: 8] = s[i];
      return k;
    endfunction

    // only the gathered characters count, stale ones beyond the length do not
    function token_key_t token_key();
      token_key_t k;
      k = '0;
      k[25:24] = 2'(tok_len);
      for (int i = 0; i < tok_len; i++) k[23-8*i -: 8] = tok[i];
      return k;
    endfunction

    function void clear_line();
      foreach (tok[i]) tok[i] = '0;
      tok_len    = 0;
      overflow   = 0;
      comp_seen  = 0;
      failed     = 0;
      in_comment = 0;
      dest       = '0;
      comp       = '0;
    endfunction

    function bit is_blank(bit [7:0] c);
      return c == 8'h20 || c == 8'h09 || c == 8'h0D || c == 8'h0A || c == 8'h0B || c == 8'h0C;
    endfunction

    function void take_char(bit [7:0] c, bit eol);
      token_key_t   k;
      bit [6:0]     comp_out;
      bit [2:0]     jump_out;
      line_result_t r;
      k = token_key();
      if (!in_comment && !is_blank(c)) begin
        if (c == CH_EQ) begin
          if (!overflow) begin
            if (dest_map.exists(k)) dest = dest_map[k][2:0];
            else failed = 1;
          end
          tok_len = 0;
        end else if (c == CH_SEMI) begin
          if (!overflow) begin
            if (comp_map.exists(k)) comp = comp_map[k];
            else failed = 1;
          end
          tok_len   = 0;
          comp_seen = 1;
        end else if (c == CH_SLASH) begin
          in_comment = 1;
        end else if (tok_len < TOKEN_CHARS) begin
          tok[tok_len] = c;
          tok_len++;
        end else begin
          overflow = 1;
        end
      end
      if (!eol) return;
      // the pending token is the jump after a ';', otherwise the compute
      k        = token_key();
      comp_out = comp;
      jump_out = '0;
      if (!overflow) begin
        if (comp_seen) begin
          if (jump_map.exists(k)) jump_out = jump_map[k][2:0];
          else failed = 1;
        end else begin
          if (comp_map.exists(k)) comp_out = comp_map[k];
          else failed = 1;
        end
      end
      if (overflow) begin
        r.word = '0;
        r.err  = ERR_OVERFLOW;
      end else if (failed) begin
        r.word = '0;
        r.err  = ERR_UNKNOWN;
      end else begin
        r.word = {PREFIX_C, comp_out, dest, jump_out};
        r.err  = ERR_NONE;
      end
      pending_words.push_back(r);
      clear_line();
    endfunction

    task report_mismatch(string msg);
      $display("mismatch on word %0d: %s", words_seen, msg);
      mismatches++;
    endtask

    task check_word(logic [23:0] d);
      line_result_t r;
      if (pending_words.size() == 0) begin
        report_mismatch($sformatf("unexpected beat %h", d));
      end else begin
        r = pending_words.pop_front();
        if (d[15:0] !== r.word)
          report_mismatch($sformatf("word %h, expected %h", d[15:0], r.word));
        if (d[17:16] !== r.err)
          report_mismatch($sformatf("error %0d, expected %0d", d[17:16], r.err));
        if (d[23:18] !== 6'd0)
          report_mismatch($sformatf("padding bits %b not zero", d[23:18]));
      end
      words_seen++;
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  line_encoder_model encoder_model = new();
  int unsigned chars_accepted = 0;
  int unsigned idle_cycles = 0;
  int unsigned burst_left = 0;
  int unsigned rx_cycle = 0;
  int unsigned rx_mode = 0;
  logic [15:0] rx_pattern = 16'hFFFF;

  always #5 clk = ~clk;

  c_instruction_encoder DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  always @(posedge clk) begin
    if (rst_n && s_tvalid && s_tready) begin
      encoder_model.take_char(s_tdata, s_tlast);
      chars_accepted++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && m_tvalid && m_tready) encoder_model.check_word(m_tdata);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL c_instruction_encoder");
        $finish;
      end
    end
  end

  // receiver: always ready, a rotating stall pattern, or random stalls
  always @(negedge clk) begin
    rx_cycle++;
    if (rx_cycle % 256 == 0) begin
      rx_mode    = $urandom_range(0, 2);
      rx_pattern = 16'($urandom_range(0, 16'hFFFF)) | 16'h0001;
    end
    case (rx_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= rx_pattern[rx_cycle % 16];
      default: m_tready <= ($urandom_range(0, 99) < 60);
    endcase
  end

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 5))
      0: return 8'h20;
      1: return 8'h09;
      2: return 8'h0D;
      3: return 8'h0A;
      4: return 8'h0B;
      default: return 8'h0C;
    endcase
  endfunction

  function automatic logic [7:0] noise_char();
    string pick;
    pick = "=;/ AMDJ01+-!&|";
    if ($urandom_range(0, 1)) return 8'($urandom_range(0, 255));
    return pick[$urandom_range(0, pick.len() - 1)];
  endfunction

  function automatic void push_char(ref logic [7:0] q[$], input logic [7:0] c, input int ws);
    if ($urandom_range(0, 99) < ws) q.push_back(blank_char());
    q.push_back(c);
  endfunction

  function automatic void push_text(ref logic [7:0] q[$], input string s, input int ws);
    for (int i = 0; i < s.len(); i++) push_char(q, s[i], ws);
  endfunction

  // mostly well-formed lines with random mnemonics, some broken, some pure noise
  function automatic void build_line(ref logic [7:0] q[$]);
    int kind;
    int ws;
    int pos;
    q.delete();
    kind = $urandom_range(0, 99);
    ws   = ($urandom_range(0, 2) == 0) ? 20 : 0;
    if (kind < 15) begin
      repeat ($urandom_range(1, 6)) q.push_back(noise_char());
    end else begin
      if ($urandom_range(0, 1)) begin
        push_text(q, encoder_model.dest_mn[$urandom_range(0, 7)], ws);
        push_char(q, CH_EQ, ws);
      end
      push_text(q, encoder_model.comp_mn[$urandom_range(0, 32)], ws);
      if ($urandom_range(0, 1)) begin
        push_char(q, CH_SEMI, ws);
        push_text(q, encoder_model.jump_mn[$urandom_range(0, 7)], ws);
      end
      if ($urandom_range(0, 6) == 0) begin
        q.push_back(CH_SLASH);
        repeat ($urandom_range(0, 4)) q.push_back(8'($urandom_range(0, 255)));
      end else if ($urandom_range(0, 9) == 0) begin
        q.push_back(blank_char());
      end
      if (kind < 30) begin
        pos = $urandom_range(0, q.size() - 1);
        if ($urandom_range(0, 1)) q[pos] = noise_char();
        else q.insert(pos, noise_char());
      end
    end
  endfunction

  // entered and left at a falling edge
  task automatic send_char(input logic [7:0] c, input logic eol);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
      end
    end
    s_tdata  <= c;
    s_tlast  <= eol;
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
  endtask

  task automatic send_line(input logic [7:0] q[$]);
    foreach (q[i]) send_char(q[i], i == q.size() - 1);
  endtask

  task automatic send_text(input string s);
    logic [7:0] q[$];
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
    send_line(q);
  endtask

  initial begin
    string       directed[7];
    logic [7:0]  line_q[$];
    directed = '{"AMD=D|M;JMP", "=0;", "\tM \v", "D/\\\f", "JMPX", ";", "m"};
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) send_text(directed[i]);
    // a nul and an all-ones byte are ordinary token characters
    line_q = '{8'h00};
    send_line(line_q);
    line_q = '{8'hFF};
    send_line(line_q);
    while (chars_accepted < CHAR_TARGET) begin
      build_line(line_q);
      send_line(line_q);
    end
    s_tvalid <= 1'b0;
    while (encoder_model.pending_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (encoder_model.mismatches == 0 && encoder_model.pending_words.size() == 0) begin
      $display("PASS c_instruction_encoder");
    end else begin
      $display("FAIL c_instruction_encoder");
    end
    $finish;
  end

endmodule
